[rtl/core/bdq_pkg.sv]
// bdq_pkg: shared types and codes for the bounded array deque
// request and result beat structs, mode and status codes, fsm states,
// controller/datapath command and status structs; no dependencies

package bdq_pkg;

  localparam int ValueWidth = 32;

  // request modes
  localparam logic [1:0] MODE_PUSH_REAR  = 2'd0;
  localparam logic [1:0] MODE_PUSH_FRONT = 2'd1;
  localparam logic [1:0] MODE_POP_FRONT  = 2'd2;
  localparam logic [1:0] MODE_POP_REAR   = 2'd3;

  // result status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]                   mode;
    logic signed [ValueWidth-1:0] push_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]                   status;
    logic signed [ValueWidth-1:0] popped_value;
  } out_beat_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } fsm_state_t;

  typedef struct packed {
    logic load;     // take in the request beat
    logic exec;     // evaluate request, update indices, drive ram
    logic capture;  // register the ram read data as popped value
  } dp_cmd_t;

  typedef struct packed {
    logic rd_pend;  // current request is a pop that reads the ram
  } dp_stat_t;

endpackage

[rtl/core/bdq_ram.sv]
// bdq_ram: generic single-port ram with registered read
// parameters set word width and depth; no dependencies

module bdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/bdq_ctrl.sv]
// bdq_ctrl: controller state machine for the bounded array deque
// sequences load, execute, ram read and response; uses bdq_pkg

module bdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  bdq_pkg::dp_stat_t dp_stat,
  output bdq_pkg::dp_cmd_t  dp_cmd
);

  bdq_pkg::fsm_state_t state_r;
  bdq_pkg::fsm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdq_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    dp_cmd         = '0;
    in_stall       = 1'b1;
    out_valid      = 1'b0;
    case (state_r)
      bdq_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          dp_cmd.load = 1'b1;
          state_nxt   = bdq_pkg::S_EXEC;
        end
      end
      bdq_pkg::S_EXEC: begin
        dp_cmd.exec = 1'b1;
        state_nxt   = dp_stat.rd_pend ? bdq_pkg::S_READ : bdq_pkg::S_RESP;
      end
      bdq_pkg::S_READ: begin
        dp_cmd.capture = 1'b1;
        state_nxt      = bdq_pkg::S_RESP;
      end
      bdq_pkg::S_RESP: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          state_nxt = bdq_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bdq_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/bdq_dpath.sv]
// bdq_dpath: datapath of the bounded array deque
// front/rear indices, empty flag, request and result registers, slot ram
// depends on bdq_pkg and bdq_ram

module bdq_dpath #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  bdq_pkg::in_beat_t  in_data,
  output bdq_pkg::out_beat_t out_data,
  input  bdq_pkg::dp_cmd_t   dp_cmd,
  output bdq_pkg::dp_stat_t  dp_stat
);

  localparam int AW = $clog2(DEPTH);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] rear_r, rear_nxt;
  logic          empty_r, empty_nxt;

  logic [1:0]                           mode_r;
  logic signed [bdq_pkg::ValueWidth-1:0] value_r;
  logic [1:0]                           status_r, status_nxt;
  logic signed [bdq_pkg::ValueWidth-1:0] popped_r;

  logic                           ram_we;
  logic                           ram_re;
  logic [AW-1:0]                  ram_addr;
  logic [bdq_pkg::ValueWidth-1:0] ram_rdata;

  always_comb begin
    front_nxt  = front_r;
    rear_nxt   = rear_r;
    empty_nxt  = empty_r;
    status_nxt = bdq_pkg::STAT_DONE;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_addr   = '0;
    case (mode_r)
      bdq_pkg::MODE_PUSH_REAR: begin
        if (empty_r) begin
          ram_we    = 1'b1;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (rear_r == LastIdx) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          ram_we   = 1'b1;
          ram_addr = rear_r + 1'b1;
          rear_nxt = rear_r + 1'b1;
        end
      end
      bdq_pkg::MODE_PUSH_FRONT: begin
        if (empty_r) begin
          ram_we    = 1'b1;
          front_nxt = '0;
          rear_nxt  = '0;
          empty_nxt = 1'b0;
        end else if (front_r == '0) begin
          status_nxt = bdq_pkg::STAT_FULL;
        end else begin
          ram_we    = 1'b1;
          ram_addr  = front_r - 1'b1;
          front_nxt = front_r - 1'b1;
        end
      end
      bdq_pkg::MODE_POP_FRONT: begin
        if (empty_r) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = front_r;
          if (front_r == rear_r) begin
            empty_nxt = 1'b1;
            front_nxt = '0;
            rear_nxt  = '0;
          end else begin
            front_nxt = front_r + 1'b1;
          end
        end
      end
      bdq_pkg::MODE_POP_REAR: begin
        if (empty_r) begin
          status_nxt = bdq_pkg::STAT_EMPTY;
        end else begin
          ram_re   = 1'b1;
          ram_addr = rear_r;
          if (front_r == rear_r) begin
            empty_nxt = 1'b1;
            front_nxt = '0;
            rear_nxt  = '0;
          end else begin
            rear_nxt = rear_r - 1'b1;
          end
        end
      end
      default: begin
        status_nxt = bdq_pkg::STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      rear_r  <= '0;
      empty_r <= 1'b1;
    end else if (dp_cmd.exec) begin
      front_r <= front_nxt;
      rear_r  <= rear_nxt;
      empty_r <= empty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      mode_r  <= in_data.mode;
      value_r <= in_data.push_value;
    end
    if (dp_cmd.exec) begin
      status_r <= status_nxt;
      popped_r <= '0;
    end else if (dp_cmd.capture) begin
      popped_r <= ram_rdata;
    end
  end

  bdq_ram #(
    .WIDTH(bdq_pkg::ValueWidth),
    .DEPTH(DEPTH)
  ) u_slots (
    .clk  (clk),
    .we   (ram_we && dp_cmd.exec),
    .re   (ram_re && dp_cmd.exec),
    .addr (ram_addr),
    .wdata(value_r),
    .rdata(ram_rdata)
  );

  assign dp_stat.rd_pend       = mode_r[1] && !empty_r;
  assign out_data.status       = status_r;
  assign out_data.popped_value = popped_r;

endmodule

[rtl/core/bounded_array_deque.sv]
// bounded_array_deque: top level, linear-array double-ended queue
// joins bdq_ctrl and bdq_dpath; depends on bdq_pkg
//
//   channel  direction  beat type            handshake
//   in_      input      bdq_pkg::in_beat_t   in_valid / in_stall
//   out_     output     bdq_pkg::out_beat_t  out_valid / out_stall
//
// one request at a time: after acceptance a push or a refused request passes
// through the execute state to the result state, and a successful pop passes
// through a read state between them, for the registered read of the slot ram
// the next request is taken in the idle state that follows the result beat;
// out_stall holds the result state and so delays the next request
// in_stall stays high from acceptance until the result beat is taken
// synchronous active-low reset empties the deque; slot contents are not cleared

module bounded_array_deque #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bdq_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bdq_pkg::out_beat_t out_data
);

  bdq_pkg::dp_cmd_t  dp_cmd;
  bdq_pkg::dp_stat_t dp_stat;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .dp_stat  (dp_stat),
    .dp_cmd   (dp_cmd)
  );

  bdq_dpath #(
    .DEPTH(DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .out_data(out_data),
    .dp_cmd  (dp_cmd),
    .dp_stat (dp_stat)
  );

endmodule

[rtl/core/bdq_check.sv]
// bdq_check: port-level assertions for bounded_array_deque
// bound to the top level below; depends on bdq_pkg

module bdq_check (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bdq_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bdq_pkg::out_beat_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !out_valid)
    else $error("result shown the cycle after acceptance");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("request taken while a result is pending");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == bdq_pkg::STAT_DONE ||
                   out_data.status == bdq_pkg::STAT_FULL ||
                   out_data.status == bdq_pkg::STAT_EMPTY))
    else $error("unknown status code");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != bdq_pkg::STAT_DONE |->
      out_data.popped_value == '0)
    else $error("refused request carries a value");

endmodule

bind bounded_array_deque bdq_check u_bdq_check (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .in_data  (in_data),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

[sim/bounded_array_deque_test.sv]
// bounded_array_deque_test: self-checking testbench for the linear-array deque
// directed corner requests, then random requests with and without random sender/receiver idling
// depends on bdq_pkg and bounded_array_deque

module bounded_array_deque_test;

  localparam int DEPTH = 4;
  localparam int SettleCycles = 6;
  localparam int DrainLimit = 5000;
  localparam int HoldCycles = 60;
  localparam int ReportLimit = 10;

  class deque_scoreboard;
    logic signed [bdq_pkg::ValueWidth-1:0] slot_mem [DEPTH];
    int unsigned head_idx;
    int unsigned tail_idx;
    bit empty;
    bdq_pkg::out_beat_t expected_q[$];
    int mismatches;

    function new();
      head_idx = 0;
      tail_idx = 0;
      empty = 1'b1;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void note_request(bdq_pkg::in_beat_t req);
      bdq_pkg::out_beat_t res;
      res.status = bdq_pkg::STAT_DONE;
      res.popped_value = '0;
      case (req.mode)
        bdq_pkg::MODE_PUSH_REAR, bdq_pkg::MODE_PUSH_FRONT: begin
          if (empty) begin
            slot_mem[0] = req.push_value;
            head_idx = 0;
            tail_idx = 0;
            empty = 1'b0;
          end else if (req.mode == bdq_pkg::MODE_PUSH_REAR) begin
            if (tail_idx == DEPTH - 1) begin
              res.status = bdq_pkg::STAT_FULL;
            end else begin
              tail_idx++;
              slot_mem[tail_idx] = req.push_value;
            end
          end else begin
            if (head_idx == 0) begin
              res.status = bdq_pkg::STAT_FULL;
            end else begin
              head_idx--;
              slot_mem[head_idx] = req.push_value;
            end
          end
        end
        default: begin
          if (empty) begin
            res.status = bdq_pkg::STAT_EMPTY;
          end else begin
            res.popped_value = (req.mode == bdq_pkg::MODE_POP_FRONT) ?
                               slot_mem[head_idx] : slot_mem[tail_idx];
            if (head_idx == tail_idx) begin
              empty = 1'b1;
              head_idx = 0;
              tail_idx = 0;
            end else if (req.mode == bdq_pkg::MODE_POP_FRONT) begin
              head_idx++;
            end else begin
              tail_idx--;
            end
          end
        end
      endcase
      expected_q.push_back(res);
    endfunction

    function void check_result(bdq_pkg::out_beat_t got);
      bdq_pkg::out_beat_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("unexpected result beat: status %0d value %h",
                   got.status, got.popped_value);
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status || got.popped_value !== want.popped_value) begin
        mismatches++;
        if (mismatches <= ReportLimit)
          $display("result beat: status exp %0d got %0d, value exp %h got %h",
                   want.status, got.status, want.popped_value, got.popped_value);
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bdq_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bdq_pkg::out_beat_t out_data;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_left = 0;

  deque_scoreboard sb;

  bounded_array_deque #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && sb != null) begin
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver: long hold-off when requested, otherwise random stalls
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_idle_pct);
      end
    end
  end

  function automatic bdq_pkg::in_beat_t make_request(logic [1:0] mode, logic [31:0] value);
    bdq_pkg::in_beat_t req;
    req.mode = mode;
    req.push_value = value;
    return req;
  endfunction

  task automatic send_beat(bdq_pkg::in_beat_t req);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_random(int count, int hold_at);
    for (int i = 0; i < count; i++) begin
      if (i == hold_at) hold_left = HoldCycles;
      send_beat(make_request(2'($urandom_range(3)), $urandom));
    end
  endtask

  task automatic drain_results();
    int waited;
    waited = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0 && waited < DrainLimit) begin
      @(negedge clk);
      waited++;
    end
    repeat (SettleCycles) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    tx_idle_pct = 22;
    rx_idle_pct = 59;

    // empty pops, front push into empty, refusals at both ends with free slots elsewhere
    send_beat(make_request(bdq_pkg::MODE_POP_FRONT, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_POP_REAR, 32'hffff_ffff));
    send_beat(make_request(bdq_pkg::MODE_PUSH_FRONT, 32'h7fff_ffff));
    send_beat(make_request(bdq_pkg::MODE_PUSH_FRONT, 32'h1111_1111));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'h8000_0000));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'hffff_ffff));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'h5a5a_5a5a));
    send_beat(make_request(bdq_pkg::MODE_POP_FRONT, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_POP_FRONT, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'h3c3c_3c3c));
    send_beat(make_request(bdq_pkg::MODE_PUSH_FRONT, 32'h1234_5678));
    send_beat(make_request(bdq_pkg::MODE_POP_REAR, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_POP_REAR, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_POP_REAR, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_POP_FRONT, 32'h0000_0000));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'ha5a5_a5a5));
    send_beat(make_request(bdq_pkg::MODE_POP_FRONT, 32'hffff_ffff));
    send_beat(make_request(bdq_pkg::MODE_PUSH_REAR, 32'h0000_0001));
    send_beat(make_request(bdq_pkg::MODE_POP_REAR, 32'h0000_0000));
    drain_results();

    run_random(130, 40);
    drain_results();

    tx_idle_pct = 59;
    rx_idle_pct = 22;
    run_random(135, 60);
    drain_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(135, -1);
    drain_results();

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("bounded_array_deque: match");
    end else begin
      $display("bounded_array_deque: mismatch");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("bounded_array_deque: mismatch");
    $finish;
  end

endmodule
